>>> rtl/triangle_face_normal_shade_unit_assert.svh
// Assertion macros shared by the shading unit RTL
`ifndef TRIANGLE_FACE_NORMAL_SHADE_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_SHADE_UNIT_ASSERT_SVH
// Check that a condition holds at every clock edge outside reset.
`define TFN_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Check that an antecedent implies a consequent on the next edge.
`define TFN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/tfns_pkg.sv
// ----------------------------------------------------------------------------
// tfns_pkg
// Shared constants and types for the face normal shading unit.
// ----------------------------------------------------------------------------
package tfns_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int NORMAL_FRAC_DEF = 14;
    localparam int REG_W           = 15;
    localparam int NORM_W          = 16;
    localparam int SHADE_W         = 15;
    localparam int IDX_W           = 1;
    localparam logic [REG_W-1:0] BASE_RESET = 15'd9830;
    localparam logic [REG_W-1:0] GAIN_RESET = 15'd6554;
    localparam logic [IDX_W-1:0] REG_BASE   = 1'b0;
    localparam logic [IDX_W-1:0] REG_GAIN   = 1'b1;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
endpackage

>>> rtl/triangle_face_normal_shade_unit.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_shade_unit
// Flat-shading face normal and per-axis shade of one triangle.
// ----------------------------------------------------------------------------
// Takes one triangle per clock while full is low. The front computes edges and
// cross product and feeds the middle queue; the back computes squares and their
// sum, a one-bit-per-stage square root over RW = 2*COORD_WIDTH+3 bits, divide
// setup, a one-bit-per-stage divide over NORMAL_FRAC_BITS bits and the shade
// stages, and its results are written into the output queue. The back pipe never
// stalls: it takes an item only while the output queue has room for everything
// in flight, so a stalled receiver fills the output queue, then the middle
// queue, and then raises full.
module triangle_face_normal_shade_unit import tfns_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [IDX_W-1:0]              i_cfg_idx,
    input  logic [REG_W-1:0]              i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_ax, i_ay, i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx, i_by, i_bz,
    input  logic signed [COORD_WIDTH-1:0] i_cx, i_cy, i_cz,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [NORM_W-1:0]      o_norm_x, o_norm_y, o_norm_z,
    output logic [SHADE_W-1:0]            o_shade_red, o_shade_green, o_shade_blue
);
    localparam int NW  = 2 * (COORD_WIDTH + 1) + 1;
    localparam int OW  = 3 * NORM_W + 3 * SHADE_W;

    logic [REG_W-1:0] r_base, r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BASE: r_base <= i_cfg_data;
                REG_GAIN: r_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output queue sized so the back pipe can always drain into it
    localparam int BLAT = 3 + (2 * (NW - 1) + 2) / 2 + 1 + NORMAL_FRAC_BITS + 2;
    localparam int OD   = 1 << $clog2(BLAT + 2);
    localparam int OPW  = $clog2(OD);

    logic          w_fvld, w_bvld, w_mvld, w_bpop, w_run;
    logic signed [NW-1:0] w_nx, w_ny, w_nz;
    logic [3*NW-1:0] w_mdata;
    logic [QPTR_W:0] w_mcnt;
    logic [NORM_W-1:0]  w_norm [3];
    logic [SHADE_W-1:0] w_shd [3];
    logic [OPW:0]   r_ocnt, r_infl;
    logic [OPW-1:0] r_owp, r_orp;
    logic [OW-1:0]  w_odata, w_ord;
    logic w_opush, w_opop;

    // front runs while the middle queue has room for its three in flight
    assign w_run = w_mcnt <= (QPTR_W+1)'(QDEPTH - 3) || w_bpop;
    assign full  = !w_run || !i_rst_n;

    tfns_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_en(w_run), .i_vld(push && w_run),
        .i_ax, .i_ay, .i_az, .i_bx, .i_by, .i_bz, .i_cx, .i_cy, .i_cz,
        .o_vld(w_fvld), .o_nx(w_nx), .o_ny(w_ny), .o_nz(w_nz)
    );

    tfns_queue #(.WIDTH(3*NW)) u_mid (
        .i_clk, .i_rst_n, .i_push(w_fvld && w_run), .i_data({w_nx, w_ny, w_nz}),
        .i_pop(w_bpop), .o_vld(w_mvld), .o_data(w_mdata), .o_count(w_mcnt)
    );

    // back takes an item while the output queue has room for everything in flight
    assign w_bpop = w_mvld && ((OPW+1)'(r_ocnt) + r_infl < (OPW+1)'(OD));

    tfns_back #(.CW(COORD_WIDTH), .FB(NORMAL_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_en(1'b1), .i_vld(w_bpop),
        .i_nx(w_mdata[3*NW-1 -: NW]), .i_ny(w_mdata[2*NW-1 -: NW]), .i_nz(w_mdata[NW-1:0]),
        .i_base(r_base), .i_gain(r_gain),
        .o_vld(w_bvld), .o_norm(w_norm), .o_shade(w_shd)
    );

    assign w_opush = w_bvld;
    assign w_opop  = pop && !empty;
    assign w_odata = {w_norm[0], w_norm[1], w_norm[2], w_shd[0], w_shd[1], w_shd[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
            r_infl <= '0;
            r_owp  <= '0;
            r_orp  <= '0;
        end else begin
            r_infl <= r_infl + (OPW+1)'(w_bpop) - (OPW+1)'(w_bvld);
            r_ocnt <= r_ocnt + (OPW+1)'(w_opush) - (OPW+1)'(w_opop);
            if (w_opush) r_owp <= r_owp + 1'b1;
            if (w_opop)  r_orp <= r_orp + 1'b1;
        end
    end

    tfns_ram #(.WIDTH(OW), .DEPTH(OD)) u_oram (
        .i_clk, .i_we(w_opush), .i_waddr(r_owp), .i_wdata(w_odata),
        .i_raddr(w_opop ? r_orp + 1'b1 : r_orp), .o_rdata(w_ord)
    );

    // read data is registered: the head is valid once the RAM read of the entry is registered
    logic r_fresh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fresh <= 1'b0;
        else r_fresh <= (r_ocnt - (OPW+1)'(w_opop)) != '0
                        || (w_opush && r_ocnt == (OPW+1)'(w_opop));
    end
    logic r_wb;
    logic [OW-1:0] r_wdat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wb <= 1'b0;
        else r_wb <= w_opush && ((w_opop ? r_orp + 1'b1 : r_orp) == r_owp);
        r_wdat <= w_odata;
    end
    logic [OW-1:0] w_head;
    assign w_head = r_wb ? r_wdat : w_ord;

    assign empty         = !(r_fresh && r_ocnt != '0);
    assign o_norm_x      = w_head[OW-1 -: NORM_W];
    assign o_norm_y      = w_head[OW-1-NORM_W -: NORM_W];
    assign o_norm_z      = w_head[OW-1-2*NORM_W -: NORM_W];
    assign o_shade_red   = w_head[3*SHADE_W-1 -: SHADE_W];
    assign o_shade_green = w_head[2*SHADE_W-1 -: SHADE_W];
    assign o_shade_blue  = w_head[SHADE_W-1:0];

    `include "triangle_face_normal_shade_unit_assert.svh"
    `TFN_ASSERT(a_out_room, r_ocnt + r_infl <= (OPW+1)'(OD), "output queue overcommitted")
    `TFN_ASSERT_NEXT(a_pop_moves, w_opop && !w_opush, r_ocnt == $past(r_ocnt) - 1'b1, "pop lost")
endmodule

>>> rtl/tfns_ram.sv
// ----------------------------------------------------------------------------
// tfns_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/tfns_front.sv
// ----------------------------------------------------------------------------
// tfns_front
// Edge and cross product stages: one triangle per cycle, while i_en is high, into a cross vector.
// ----------------------------------------------------------------------------
module tfns_front import tfns_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    localparam int EW = CW + 1,
    localparam int NW = 2 * EW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_ax, i_ay, i_az,
    input  logic signed [CW-1:0] i_bx, i_by, i_bz,
    input  logic signed [CW-1:0] i_cx, i_cy, i_cz,
    output logic                 o_vld,
    output logic signed [NW-1:0] o_nx, o_ny, o_nz
);
    logic                   r_v1, r_v2, r_v3;
    logic signed [EW-1:0]   r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [2*EW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [NW-1:0]   r_nx, r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1x <= EW'(i_bx) - EW'(i_ax);
            r_e1y <= EW'(i_by) - EW'(i_ay);
            r_e1z <= EW'(i_bz) - EW'(i_az);
            r_e2x <= EW'(i_cx) - EW'(i_ax);
            r_e2y <= EW'(i_cy) - EW'(i_ay);
            r_e2z <= EW'(i_cz) - EW'(i_az);
            r_p0  <= r_e1y * r_e2z;
            r_p1  <= r_e1z * r_e2y;
            r_p2  <= r_e1z * r_e2x;
            r_p3  <= r_e1x * r_e2z;
            r_p4  <= r_e1x * r_e2y;
            r_p5  <= r_e1y * r_e2x;
            r_nx  <= NW'(r_p0) - NW'(r_p1);
            r_ny  <= NW'(r_p2) - NW'(r_p3);
            r_nz  <= NW'(r_p4) - NW'(r_p5);
        end
    end

    assign o_vld = r_v3;
    assign o_nx  = r_nx;
    assign o_ny  = r_ny;
    assign o_nz  = r_nz;
endmodule

>>> rtl/tfns_queue.sv
// ----------------------------------------------------------------------------
// tfns_queue
// Short queue between the front and back parts, with skid room for the
// front pipeline in flight.
// ----------------------------------------------------------------------------
module tfns_queue import tfns_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_data,
    output logic [QPTR_W:0]  o_count
);
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic [WIDTH-1:0]  r_mem [QDEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_vld   = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    `include "triangle_face_normal_shade_unit_assert.svh"
    `TFN_ASSERT(a_no_overflow, !(i_push && !i_pop && r_cnt == (QPTR_W+1)'(QDEPTH)), "queue overflow")
    `TFN_ASSERT(a_no_underflow, !(i_pop && r_cnt == '0), "queue underflow")
    `TFN_ASSERT_NEXT(a_cnt_hold, i_push == i_pop, $stable(r_cnt), "count moved")
endmodule

>>> rtl/tfns_back.sv
// ----------------------------------------------------------------------------
// tfns_back
// Squared length, pipelined square root, pipelined divides and shades.
// ----------------------------------------------------------------------------
module tfns_back import tfns_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int FB = NORMAL_FRAC_DEF,
    localparam int NW = 2 * (CW + 1) + 1,
    localparam int MW = NW - 1,
    localparam int SW = 2 * MW + 2,
    localparam int RW = SW / 2,
    localparam int DW = RW + 1,
    localparam int QW = FB + 1,
    localparam int LAT = 3 + RW + 1 + FB + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [NW-1:0] i_nx, i_ny, i_nz,
    input  logic [REG_W-1:0]     i_base,
    input  logic [REG_W-1:0]     i_gain,
    output logic                 o_vld,
    output logic [NORM_W-1:0]    o_norm [3],
    output logic [SHADE_W-1:0]   o_shade [3]
);
    logic [LAT-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[LAT-2:0], i_vld};
    end
    assign o_vld = r_v[LAT-1];

    // magnitude stage, then square stage
    logic [MW-1:0] r_m1 [3];
    logic          r_s1 [3];
    logic [2*MW-1:0] r_sq [3];
    logic [MW-1:0] r_m2 [3];
    logic          r_s2 [3];
    logic signed [NW-1:0] w_n [3];
    assign w_n[0] = i_nx;
    assign w_n[1] = i_ny;
    assign w_n[2] = i_nz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_m1[k] <= w_n[k][NW-1] ? MW'(-w_n[k]) : MW'(w_n[k]);
                r_s1[k] <= w_n[k][NW-1];
                r_sq[k] <= r_m1[k] * r_m1[k];
                r_m2[k] <= r_m1[k];
                r_s2[k] <= r_s1[k];
            end
        end
    end

    // square root: one result bit per stage
    logic [SW-1:0] r_rad [RW+1];
    logic [DW+1:0] r_rem [RW+1];
    logic [RW-1:0] r_root [RW+1];
    logic [MW-1:0] r_rm [RW+1][3];
    logic          r_rs [RW+1][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int k = 0; k < 3; k++) begin
                r_rm[0][k] <= r_m2[k];
                r_rs[0][k] <= r_s2[k];
            end
        end
    end

    for (genvar s = 0; s < RW; s++) begin : g_sqrt
        logic [DW+1:0] w_rem, w_trial;
        assign w_rem   = {r_rem[s][DW-1:0], r_rad[s][SW-1 -: 2]};
        assign w_trial = (DW+2)'({r_root[s], 2'b01});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s+1] <= r_rad[s] << 2;
                if (w_rem >= w_trial) begin
                    r_rem[s+1]  <= w_rem - w_trial;
                    r_root[s+1] <= {r_root[s][RW-2:0], 1'b1};
                end else begin
                    r_rem[s+1]  <= w_rem;
                    r_root[s+1] <= {r_root[s][RW-2:0], 1'b0};
                end
                for (int k = 0; k < 3; k++) begin
                    r_rm[s+1][k] <= r_rm[s][k];
                    r_rs[s+1][k] <= r_rs[s][k];
                end
            end
        end
    end

    // divide setup: saturate and zero length decided here
    logic [RW-1:0] r_len [FB+1];
    logic [RW:0]   r_dr [FB+1][3];
    logic [QW-1:0] r_q [FB+1][3];
    logic          r_sat [FB+1][3];
    logic          r_ds [FB+1][3];
    logic [RW-1:0] w_len;
    assign w_len = r_root[RW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0] <= w_len;
            for (int k = 0; k < 3; k++) begin
                r_sat[0][k] <= (w_len != '0) && ((RW+1)'(r_rm[RW][k]) >= (RW+1)'(w_len));
                r_dr[0][k]  <= (w_len == '0) ? '0 : (RW+1)'(r_rm[RW][k]);
                r_q[0][k]   <= '0;
                r_ds[0][k]  <= r_rs[RW][k];
            end
        end
    end

    for (genvar s = 0; s < FB; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[s+1] <= r_len[s];
                for (int k = 0; k < 3; k++) begin
                    logic [RW+1:0] t;
                    t = {r_dr[s][k], 1'b0};
                    if (r_len[s] != '0 && t >= (RW+2)'(r_len[s])) begin
                        r_dr[s+1][k] <= (RW+1)'(t - (RW+2)'(r_len[s]));
                        r_q[s+1][k]  <= {r_q[s][k][QW-2:0], 1'b1};
                    end else begin
                        r_dr[s+1][k] <= (RW+1)'(t);
                        r_q[s+1][k]  <= {r_q[s][k][QW-2:0], 1'b0};
                    end
                    r_sat[s+1][k] <= r_sat[s][k];
                    r_ds[s+1][k]  <= r_ds[s][k];
                end
            end
        end
    end

    // shade: multiply, then add and saturate
    logic [QW-1:0]       r_um [3];
    logic                r_us [3];
    logic [REG_W+QW-1:0] r_pr [3];
    logic [NORM_W-1:0]   r_nrm1 [3], r_nrm2 [3];
    logic [SHADE_W-1:0]  r_shd [3];
    logic [QW-1:0]       w_um [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_um[k] = r_sat[FB][k] ? QW'(1) << FB : r_q[FB][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                logic [REG_W:0] s;
                r_um[k]   <= w_um[k];
                r_us[k]   <= r_ds[FB][k];
                r_pr[k]   <= i_gain * w_um[k];
                r_nrm1[k] <= r_ds[FB][k] ? NORM_W'(-(NORM_W+QW)'(w_um[k]))
                                         : NORM_W'(w_um[k]);
                s = (REG_W+1)'(i_base) + (REG_W+1)'(r_pr[k] >> FB);
                r_shd[k]  <= s[REG_W] ? {SHADE_W{1'b1}} : s[SHADE_W-1:0];
                r_nrm2[k] <= r_nrm1[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_norm[k]  = r_nrm2[k];
            o_shade[k] = r_shd[k];
        end
    end

    `include "triangle_face_normal_shade_unit_assert.svh"
    `TFN_ASSERT(a_um_limit, !(r_v[LAT-2] && (r_um[0] > (QW'(1) << FB))), "normal over limit")
    `TFN_ASSERT_NEXT(a_stall_hold, !i_en, $stable(r_v), "pipe moved in stall")
endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the face normal shading unit: triangles go in through
// the push side, each result beat is compared with a local integer model of the
// edge/cross/sqrt/divide/shade datapath under several shade register settings
// and several sender and receiver idle patterns, including a long stall.
// ----------------------------------------------------------------------------
module testbench;
    import tfns_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic [SHADE_W-1:0]       sr, sg, sb;
    } shade_beat_t;

    typedef logic signed [15:0] vtx_t [9];

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [IDX_W-1:0]        cfg_idx = REG_BASE;
    logic [REG_W-1:0]        cfg_data = '0;
    logic                    push = 1'b0;
    logic                    full;
    logic signed [15:0]      ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
    logic signed [15:0]      cx = 0, cy = 0, cz = 0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic signed [NORM_W-1:0] o_nx, o_ny, o_nz;
    logic [SHADE_W-1:0]      o_sr, o_sg, o_sb;

    shade_beat_t  pending_shades[$];
    logic [REG_W-1:0] base_reg = BASE_RESET;
    logic [REG_W-1:0] gain_reg = GAIN_RESET;
    int           send_idle_pct = 0;
    int           pop_stall_pct = 0;
    int           hold_cycles = 0;
    int           hold_request = 0;
    int           fail_count = 0;
    int           cycle_count = 0;

    triangle_face_normal_shade_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .push(push), .full(full),
        .i_ax(ax), .i_ay(ay), .i_az(az), .i_bx(bx), .i_by(by), .i_bz(bz),
        .i_cx(cx), .i_cy(cy), .i_cz(cz),
        .empty(empty), .pop(pop),
        .o_norm_x(o_nx), .o_norm_y(o_ny), .o_norm_z(o_nz),
        .o_shade_red(o_sr), .o_shade_green(o_sg), .o_shade_blue(o_sb)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [63:0]  root;
        logic [127:0] rem;
        logic [127:0] trial;
        root = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
            trial = ({64'd0, root} << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic shade_beat_t face_shade(vtx_t v);
        longint      e1[3], e2[3], n[3], mag[3];
        logic [127:0] sq;
        logic [63:0] len, um, r, q;
        logic [31:0] sh;
        logic [NORM_W-1:0] nv[3];
        logic [SHADE_W-1:0] sv[3];
        shade_beat_t res;
        for (int k = 0; k < 3; k++) begin
            e1[k] = longint'(v[3 + k]) - longint'(v[k]);
            e2[k] = longint'(v[6 + k]) - longint'(v[k]);
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sq = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = n[k] < 0 ? -n[k] : n[k];
            sq = sq + 128'(mag[k]) * 128'(mag[k]);
        end
        len = isqrt(sq);
        for (int k = 0; k < 3; k++) begin
            um = 0;
            if (len != 0) begin
                if (mag[k] >= len) begin
                    um = 64'd16384;
                end else begin
                    q = 0;
                    r = mag[k];
                    for (int i = 0; i < 14; i++) begin
                        q = q << 1;
                        r = r << 1;
                        if (r >= len) begin
                            r = r - len;
                            q = q | 64'd1;
                        end
                    end
                    um = q;
                end
            end
            nv[k] = n[k] < 0 ? NORM_W'(-um) : NORM_W'(um);
            sh = 32'(base_reg) + ((32'(gain_reg) * 32'(um)) >> 14);
            sv[k] = sh > 32767 ? 15'd32767 : sh[14:0];
        end
        res.nx = nv[0]; res.ny = nv[1]; res.nz = nv[2];
        res.sr = sv[0]; res.sg = sv[1]; res.sb = sv[2];
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    // receiver: check each beat against the oldest pending shade
    always @(posedge i_clk) begin
        shade_beat_t want;
        if (pop && !empty) begin
            if (pending_shades.size() == 0) begin
                report("unexpected beat", 1, 0);
            end else begin
                want = pending_shades.pop_front();
                if (o_nx !== want.nx) report("norm_x", o_nx, want.nx);
                if (o_ny !== want.ny) report("norm_y", o_ny, want.ny);
                if (o_nz !== want.nz) report("norm_z", o_nz, want.nz);
                if (o_sr !== want.sr) report("shade_red", o_sr, want.sr);
                if (o_sg !== want.sg) report("shade_green", o_sg, want.sg);
                if (o_sb !== want.sb) report("shade_blue", o_sb, want.sb);
            end
        end
        pop <= i_rst_n && hold_cycles == 0 && $urandom_range(99) >= pop_stall_pct;
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_cycles <= hold_request;
            hold_request <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    task automatic send_tri(vtx_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        ax <= v[0]; ay <= v[1]; az <= v[2];
        bx <= v[3]; by <= v[4]; bz <= v[5];
        cx <= v[6]; cy <= v[7]; cz <= v[8];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_shades.insert(pending_shades.size(), face_shade(v));
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_shades.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_BASE) base_reg = data;
        else gain_reg = data;
    endtask

    function automatic vtx_t rand_tri();
        vtx_t v;
        int   mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 9; k++) begin
            if (mode < 5) v[k] = 16'($urandom);
            else if (mode < 8) v[k] = $signed(16'($urandom_range(512))) - 16'sd256;
            else v[k] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
        if ($urandom_range(19) == 0) begin
            for (int k = 0; k < 3; k++) v[6 + k] = v[$urandom_range(1) * 3 + k];
        end
        return v;
    endfunction

    task automatic test_directed();
        vtx_t v;
        v = '{default: 0};
        send_tri(v);
        v = '{default: 16'sh7fff};
        send_tri(v);
        v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        send_tri(v);
        v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
        send_tri(v);
        v = '{0, 0, 0, 0, 0, 256, 256, 0, 0};
        send_tri(v);
        v = '{0, 0, 0, 0, 256, 0, 0, 0, 256};
        send_tri(v);
        v = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        send_tri(v);
        v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        send_tri(v);
        v = '{-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767};
        send_tri(v);
        v = '{100, 100, 100, 200, 200, 200, 300, 300, 300};
        send_tri(v);
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 1};
        send_tri(v);
        v = '{-32768, 32767, 0, 32767, -32768, 32767, 0, 0, -32768};
        send_tri(v);
        v = '{1, -1, 1, -1, 1, -1, 300, 7, -90};
        send_tri(v);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) send_tri(rand_tri());
        drain();
    endtask

    task automatic test_registers();
        write_reg(REG_BASE, 15'd0);
        write_reg(REG_GAIN, 15'd0);
        test_random(20, 0, 0);
        write_reg(REG_BASE, 15'd16384);
        write_reg(REG_GAIN, 15'd16384);
        test_directed();
        test_random(20, 0, 0);
        write_reg(REG_BASE, 15'd32767);
        write_reg(REG_GAIN, 15'd32767);
        test_random(20, 0, 0);
        write_reg(REG_BASE, 15'd0);
        test_random(20, 0, 0);
        write_reg(REG_BASE, 15'($urandom_range(16384)));
        write_reg(REG_GAIN, 15'($urandom));
        test_random(20, 0, 0);
        write_reg(REG_BASE, BASE_RESET);
        write_reg(REG_GAIN, GAIN_RESET);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_request = 300;
        for (int i = 0; i < 100; i++) send_tri(rand_tri());
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain();
        test_registers();
        test_random(80, 0, 0);
        test_random(80, 49, 0);
        test_random(80, 0, 49);
        test_random(80, 9, 9);
        test_backpressure();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/tfns_pkg.sv
rtl/tfns_ram.sv
rtl/tfns_front.sv
rtl/tfns_queue.sv
rtl/tfns_back.sv
rtl/triangle_face_normal_shade_unit.sv
sim/testbench.sv
